>>> hw/rtl/siocp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// siocp_pkg: shared types and constants of the serial I/O command parser
// Holds the job descriptor passed from the front end to the reply engine,
// the result kind codes and the ASCII characters of the command protocol.
// ----------------------------------------------------------------------------
package siocp_pkg;

  // Stream widths: fields packed from bit 0 up, padded to whole bytes
  localparam int IN_TDATA_W  = 32;  // rx_byte, pin_inputs, adc_value, tx_ready
  localparam int OUT_TDATA_W = 24;  // reply_byte, led_outputs, conv_channel

  // Protocol characters
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_A       = 8'h41;
  localparam logic [7:0] CH_B       = 8'h42;
  localparam logic [7:0] CH_C       = 8'h43;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [3:0] ASCII_HI   = 4'h3;   // upper nibble of '0'..'?'

  // Result kinds on the output stream
  typedef enum logic [1:0] {
    KIND_LED   = 2'd0,
    KIND_REPLY = 2'd1,
    KIND_CONV  = 2'd2
  } res_kind_e;

  // Work classified by the front end, expanded by the reply engine
  typedef enum logic [2:0] {
    JOB_SET,         // one output-bit update word
    JOB_STATUS,      // five-byte status reply
    JOB_SET_STATUS,  // update word followed by the status reply
    JOB_CONV_REQ,    // one start-conversion word
    JOB_CONV_REPLY   // eight-byte conversion reply
  } job_kind_e;

  typedef struct packed {
    job_kind_e   kind;
    logic [7:0]  led;    // output bits after the item
    logic [7:0]  pins;   // input pin levels for a status reply
    logic [2:0]  chan;   // channel of a request or a reply
    logic [9:0]  adc;    // converter result for a reply
  } job_t;

endpackage

>>> hw/rtl/siocp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// siocp_front: command matchers and job classifier
// Runs the set, status and conversion matchers on each accepted item and
// pushes one job descriptor for every item that produces results.
// ----------------------------------------------------------------------------
module siocp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic              op_i,
  input  logic [7:0]        rx_byte_i,
  input  logic [7:0]        pins_i,
  input  logic [9:0]        adc_i,
  input  logic              tx_ready_i,
  output logic              push_o,
  output siocp_pkg::job_t   job_o
);

  typedef enum logic [2:0] {
    SET_IDLE, SET_GOT_STAR, SET_WAIT_CHAN, SET_WAIT_VAL, SET_WAIT_CR
  } set_state_e;

  typedef enum logic [1:0] {
    STS_IDLE, STS_GOT_STAR, STS_WAIT_CR
  } sts_state_e;

  typedef enum logic [1:0] {
    CNV_IDLE, CNV_GOT_STAR, CNV_WAIT_CHAN, CNV_WAIT_CR
  } cnv_state_e;

  set_state_e set_q, set_d;
  sts_state_e sts_q, sts_d;
  cnv_state_e cnv_q, cnv_d;
  logic [2:0] set_chan_q, set_chan_d;
  logic       set_val_q, set_val_d;
  logic [2:0] cnv_sel_q, cnv_sel_d;
  logic [7:0] bits_q, bits_d;
  logic       pend_q, pend_d;
  logic [2:0] pend_chan_q, pend_chan_d;
  logic       fire_set, fire_sts, fire_req, fire_rep;
  logic       is_cr, is_star;

  assign is_cr   = (rx_byte_i == siocp_pkg::CH_CR);
  assign is_star = (rx_byte_i == siocp_pkg::CH_STAR);

  always_comb begin
    set_d       = set_q;
    sts_d       = sts_q;
    cnv_d       = cnv_q;
    set_chan_d  = set_chan_q;
    set_val_d   = set_val_q;
    cnv_sel_d   = cnv_sel_q;
    bits_d      = bits_q;
    pend_d      = pend_q;
    pend_chan_d = pend_chan_q;
    fire_set    = 1'b0;
    fire_sts    = 1'b0;
    fire_req    = 1'b0;
    fire_rep    = 1'b0;
    if (accept_i && !op_i) begin
      case (set_q)
        SET_IDLE:      if (is_star) set_d = SET_GOT_STAR;
        SET_GOT_STAR:  set_d = (rx_byte_i == siocp_pkg::CH_A) ? SET_WAIT_CHAN : SET_IDLE;
        SET_WAIT_CHAN: begin
          set_chan_d = rx_byte_i[2:0];
          set_d      = SET_WAIT_VAL;
        end
        SET_WAIT_VAL: begin
          set_val_d = rx_byte_i[0];
          set_d     = SET_WAIT_CR;
        end
        default: begin
          if (is_cr) begin
            bits_d[set_chan_q] = set_val_q;
            fire_set           = 1'b1;
          end
          set_d = SET_IDLE;
        end
      endcase
      case (sts_q)
        STS_IDLE:     if (is_star) sts_d = STS_GOT_STAR;
        STS_GOT_STAR: sts_d = (rx_byte_i == siocp_pkg::CH_B) ? STS_WAIT_CR : STS_IDLE;
        default: begin
          fire_sts = is_cr && tx_ready_i;
          sts_d    = STS_IDLE;
        end
      endcase
      case (cnv_q)
        CNV_IDLE:      if (is_star) cnv_d = CNV_GOT_STAR;
        CNV_GOT_STAR:  cnv_d = (rx_byte_i == siocp_pkg::CH_C) ? CNV_WAIT_CHAN : CNV_IDLE;
        CNV_WAIT_CHAN: begin
          cnv_sel_d = rx_byte_i[2:0];
          cnv_d     = CNV_WAIT_CR;
        end
        default: begin
          if (is_cr) begin
            pend_d      = 1'b1;
            pend_chan_d = cnv_sel_q;
            fire_req    = 1'b1;
          end
          cnv_d = CNV_IDLE;
        end
      endcase
    end else if (accept_i && op_i && pend_q) begin
      // consume the request even when the reply is dropped
      pend_d   = 1'b0;
      fire_rep = tx_ready_i;
    end
  end

  always_comb begin
    if (fire_rep) begin
      job_o.kind = siocp_pkg::JOB_CONV_REPLY;
    end else if (fire_set && fire_sts) begin
      job_o.kind = siocp_pkg::JOB_SET_STATUS;
    end else if (fire_set) begin
      job_o.kind = siocp_pkg::JOB_SET;
    end else if (fire_sts) begin
      job_o.kind = siocp_pkg::JOB_STATUS;
    end else begin
      job_o.kind = siocp_pkg::JOB_CONV_REQ;
    end
    job_o.led  = bits_d;
    job_o.pins = pins_i;
    job_o.chan = fire_rep ? pend_chan_q : cnv_sel_q;
    job_o.adc  = adc_i;
  end

  assign push_o = fire_set | fire_sts | fire_req | fire_rep;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_q       <= SET_IDLE;
      sts_q       <= STS_IDLE;
      cnv_q       <= CNV_IDLE;
      set_chan_q  <= '0;
      set_val_q   <= 1'b0;
      cnv_sel_q   <= '0;
      bits_q      <= '0;
      pend_q      <= 1'b0;
      pend_chan_q <= '0;
    end else begin
      set_q       <= set_d;
      sts_q       <= sts_d;
      cnv_q       <= cnv_d;
      set_chan_q  <= set_chan_d;
      set_val_q   <= set_val_d;
      cnv_sel_q   <= cnv_sel_d;
      bits_q      <= bits_d;
      pend_q      <= pend_d;
      pend_chan_q <= pend_chan_d;
    end
  end

endmodule

>>> hw/rtl/siocp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// siocp_queue: job queue between front end and reply engine
// Small register FIFO of job descriptors with a first-word view at the head.
// ----------------------------------------------------------------------------
module siocp_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  siocp_pkg::job_t push_job_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            head_valid_o,
  output siocp_pkg::job_t head_job_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  siocp_pkg::job_t mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;

  function automatic logic [PTR_W-1:0] nxt(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o       = (cnt_q == CNT_W'(DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= nxt(wr_q);
      end
      if (pop_i) begin
        rd_q <= nxt(rd_q);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

>>> hw/rtl/siocp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// siocp_back: reply engine
// Expands the job at the queue head into result words, one per cycle while
// the output is not stalled, into an output register; converts the converter
// result to decimal one digit per word.
// ----------------------------------------------------------------------------
module siocp_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  head_valid_i,
  input  siocp_pkg::job_t       head_job_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  out_last_o,
  output siocp_pkg::res_kind_e  out_kind_o,
  output logic [7:0]            out_byte_o,
  output logic [7:0]            out_led_o,
  output logic [2:0]            out_chan_o
);

  logic                 valid_q;
  logic                 last_q;
  siocp_pkg::res_kind_e kind_q;
  logic [7:0]           byte_q, led_q;
  logic [2:0]           chan_q;
  logic [2:0]           idx_q;
  logic [9:0]           dig_q;

  logic                 advance, emit, last_w;
  siocp_pkg::res_kind_e kind_w;
  logic [7:0]           byte_w, sts_byte, rep_byte;
  logic [2:0]           chan_w, sts_idx;
  logic [9:0]           dig_src, rem_full;
  logic [17:0]          prod;
  logic [6:0]           quot;

  assign advance = !valid_q || out_ready_i;
  assign emit    = head_valid_i && advance;
  assign pop_o   = emit && last_w;

  // divide by ten via reciprocal 205/2048, exact below 1029
  assign dig_src  = (idx_q == 3'd3) ? head_job_i.adc : dig_q;
  assign prod     = 18'(dig_src) * 18'd205;
  assign quot     = prod[17:11];
  assign rem_full = dig_src - {quot, 3'b000} - {2'b00, quot, 1'b0};

  assign sts_idx = (head_job_i.kind == siocp_pkg::JOB_SET_STATUS) ? idx_q - 3'd1 : idx_q;

  always_comb begin
    case (sts_idx)
      3'd0:    sts_byte = siocp_pkg::CH_STAR;
      3'd1:    sts_byte = siocp_pkg::CH_B;
      3'd2:    sts_byte = {siocp_pkg::ASCII_HI, head_job_i.pins[3:0]};
      3'd3:    sts_byte = {siocp_pkg::ASCII_HI, head_job_i.pins[7:4]};
      default: sts_byte = siocp_pkg::CH_CR;
    endcase
  end

  always_comb begin
    case (idx_q)
      3'd0:    rep_byte = siocp_pkg::CH_STAR;
      3'd1:    rep_byte = siocp_pkg::CH_C;
      3'd2:    rep_byte = {siocp_pkg::ASCII_HI, 1'b0, head_job_i.chan};
      3'd7:    rep_byte = siocp_pkg::CH_CR;
      default: rep_byte = {siocp_pkg::ASCII_HI, rem_full[3:0]};
    endcase
  end

  always_comb begin
    kind_w = siocp_pkg::KIND_REPLY;
    byte_w = 8'd0;
    chan_w = 3'd0;
    last_w = 1'b1;
    case (head_job_i.kind)
      siocp_pkg::JOB_SET: begin
        kind_w = siocp_pkg::KIND_LED;
      end
      siocp_pkg::JOB_STATUS: begin
        byte_w = sts_byte;
        last_w = (idx_q == 3'd4);
      end
      siocp_pkg::JOB_SET_STATUS: begin
        kind_w = (idx_q == 3'd0) ? siocp_pkg::KIND_LED : siocp_pkg::KIND_REPLY;
        byte_w = (idx_q == 3'd0) ? 8'd0 : sts_byte;
        last_w = (idx_q == 3'd5);
      end
      siocp_pkg::JOB_CONV_REQ: begin
        kind_w = siocp_pkg::KIND_CONV;
        chan_w = head_job_i.chan;
      end
      siocp_pkg::JOB_CONV_REPLY: begin
        byte_w = rep_byte;
        last_w = (idx_q == 3'd7);
      end
      default: begin
        last_w = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      last_q <= last_w;
      kind_q <= kind_w;
      byte_q <= byte_w;
      led_q  <= head_job_i.led;
      chan_q <= chan_w;
      dig_q  <= {3'b000, quot};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (emit) begin
      valid_q <= 1'b1;
      idx_q   <= last_w ? 3'd0 : idx_q + 3'd1;
    end else if (advance) begin
      valid_q <= 1'b0;
    end
  end

  assign out_valid_o = valid_q;
  assign out_last_o  = last_q;
  assign out_kind_o  = kind_q;
  assign out_byte_o  = byte_q;
  assign out_led_o   = led_q;
  assign out_chan_o  = chan_q;

endmodule

>>> hw/rtl/serial_io_command_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_io_command_parser_top: serial I/O command parser
// Parses "*A<ch><v>CR", "*B CR" and "*C<ch>CR" commands from a byte stream
// and emits output-bit updates, conversion requests and ASCII replies.
//
// Input words (s_axis): tuser selects a command byte (0) or a conversion
// completion (1); tdata carries the byte, the input pin levels, the converter
// result and the transmitter-ready flag. Output words (m_axis): tuser gives
// the kind (bits updated, reply byte, start conversion), tlast marks the
// last word caused by one input word.
// The front end takes one input word per cycle while the job queue has room
// (QUEUE_DEPTH jobs). The reply engine drains one output word per cycle while
// the receiver does not stall; each job expands to between one and eight
// words. With an empty queue and a free output register, the first word of an
// item passes through the job queue and then the output register.
// When the receiver stalls, the output register holds its word,
// the queue fills, and s_axis_tready drops only once the queue is full.
// Reset clears the matchers, the output bits, any pending conversion, the
// queue and the output register.
// ----------------------------------------------------------------------------
module serial_io_command_parser_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [7:0] rx_byte, [15:8] pin_inputs, [25:16] adc_value, [26] tx_ready
  input  logic [siocp_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // [0] op
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [7:0] reply_byte, [15:8] led_outputs, [18:16] conv_channel
  output logic [siocp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // [1:0] kind
  output logic [1:0]                        m_axis_tuser,
  output logic                              m_axis_tlast
);

  logic                 accept;
  logic                 q_full, q_push, q_pop, q_valid;
  siocp_pkg::job_t      push_job, head_job;
  siocp_pkg::res_kind_e out_kind;
  logic [7:0]           out_byte, out_led;
  logic [2:0]           out_chan;

  // Accept while the queue has room; an item that yields nothing pushes no job
  assign s_axis_tready = !q_full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  siocp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .op_i       (s_axis_tuser),
    .rx_byte_i  (s_axis_tdata[7:0]),
    .pins_i     (s_axis_tdata[15:8]),
    .adc_i      (s_axis_tdata[25:16]),
    .tx_ready_i (s_axis_tdata[26]),
    .push_o     (q_push),
    .job_o      (push_job)
  );

  siocp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_job_i   (push_job),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .head_valid_o (q_valid),
    .head_job_o   (head_job)
  );

  siocp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_valid),
    .head_job_i   (head_job),
    .pop_o        (q_pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_last_o   (m_axis_tlast),
    .out_kind_o   (out_kind),
    .out_byte_o   (out_byte),
    .out_led_o    (out_led),
    .out_chan_o   (out_chan)
  );

  // Pack the result word, padding to whole bytes
  assign m_axis_tdata = {5'b00000, out_chan, out_led, out_byte};
  assign m_axis_tuser = out_kind;

  // Retire a job only while one is at the head
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> q_valid)
    else $error("job popped from empty queue");

  // The word that retires a job is the one shown next, marked last
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |=> (m_axis_tvalid && m_axis_tlast))
    else $error("retired job did not end with a last word");

  // Never push into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_push |-> !q_full)
    else $error("job pushed into full queue");

endmodule

>>> test/tb_serial_io_command_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_serial_io_command_parser_top: self-checking bench of the command parser
// Streams command bytes and conversion completions into the parser, tracks
// its matchers, output bits and pending conversion in a scoreboard, and
// compares every output word field by field with the predicted word. Runs a
// short directed sequence, then random command traffic under three idling
// mixes on the input and output streams.
// ----------------------------------------------------------------------------
module tb_serial_io_command_parser_top;

  localparam logic OP_BYTE = 1'b0;  // word carries a received command byte
  localparam logic OP_DONE = 1'b1;  // word reports a finished conversion
  localparam int   CYCLE_LIMIT = 400000;
  localparam int   TAIL_CYCLES = 20;

  // One predicted output word
  typedef struct {
    siocp_pkg::res_kind_e kind;
    logic [7:0]           reply;
    logic                 last;
    logic [7:0]           led;
    logic [2:0]           chan;
  } out_word_t;

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors the three matchers and the output state, and holds
  // the words the parser still owes in arrival order.
  // --------------------------------------------------------------------------
  class cmd_scoreboard;
    logic [2:0] set_pos;     // bytes of "*A<ch><v>" matched so far
    logic [1:0] status_pos;  // bytes of "*B" matched so far
    logic [1:0] conv_pos;    // bytes of "*C<ch>" matched so far
    logic [2:0] set_ch;
    logic       set_val;
    logic [2:0] conv_ch;
    logic [7:0] led_bits;
    logic       conv_pending;
    logic [2:0] pend_ch;
    out_word_t  owed_words[$];
    out_word_t  batch[$];
    int         errors;

    function new();
      set_pos      = '0;
      status_pos   = '0;
      conv_pos     = '0;
      set_ch       = '0;
      set_val      = 1'b0;
      conv_ch      = '0;
      led_bits     = '0;
      conv_pending = 1'b0;
      pend_ch      = '0;
      errors       = 0;
    endfunction

    // Words carry the output bits as they stand when the word is produced
    function void add(siocp_pkg::res_kind_e kind, logic [7:0] ch, logic [2:0] chan);
      out_word_t w;
      w.kind  = kind;
      w.reply = ch;
      w.last  = 1'b0;
      w.led   = led_bits;
      w.chan  = chan;
      batch.push_back(w);
    endfunction

    function void note_word(logic op, logic [7:0] rx, logic [7:0] pins,
                            logic [9:0] adc, logic ready);
      logic [9:0] rest;
      int         k;
      batch.delete();
      if (op == OP_BYTE) begin
        // Set matcher runs first, so its word precedes a status reply
        case (set_pos)
          3'd0: if (rx == siocp_pkg::CH_STAR) set_pos = 3'd1;
          3'd1: set_pos = (rx == siocp_pkg::CH_A) ? 3'd2 : 3'd0;
          3'd2: begin
            set_ch  = rx[2:0];
            set_pos = 3'd3;
          end
          3'd3: begin
            set_val = rx[0];
            set_pos = 3'd4;
          end
          default: begin
            if (rx == siocp_pkg::CH_CR) begin
              led_bits[set_ch] = set_val;
              add(siocp_pkg::KIND_LED, 8'h00, 3'd0);
            end
            set_pos = 3'd0;
          end
        endcase
        case (status_pos)
          2'd0: if (rx == siocp_pkg::CH_STAR) status_pos = 2'd1;
          2'd1: status_pos = (rx == siocp_pkg::CH_B) ? 2'd2 : 2'd0;
          default: begin
            if (rx == siocp_pkg::CH_CR && ready) begin
              add(siocp_pkg::KIND_REPLY, siocp_pkg::CH_STAR, 3'd0);
              add(siocp_pkg::KIND_REPLY, siocp_pkg::CH_B, 3'd0);
              add(siocp_pkg::KIND_REPLY, {siocp_pkg::ASCII_HI, pins[3:0]}, 3'd0);
              add(siocp_pkg::KIND_REPLY, {siocp_pkg::ASCII_HI, pins[7:4]}, 3'd0);
              add(siocp_pkg::KIND_REPLY, siocp_pkg::CH_CR, 3'd0);
            end
            status_pos = 2'd0;
          end
        endcase
        case (conv_pos)
          2'd0: if (rx == siocp_pkg::CH_STAR) conv_pos = 2'd1;
          2'd1: conv_pos = (rx == siocp_pkg::CH_C) ? 2'd2 : 2'd0;
          2'd2: begin
            conv_ch  = rx[2:0];
            conv_pos = 2'd3;
          end
          default: begin
            if (rx == siocp_pkg::CH_CR) begin
              conv_pending = 1'b1;
              pend_ch      = conv_ch;
              add(siocp_pkg::KIND_CONV, 8'h00, conv_ch);
            end
            conv_pos = 2'd0;
          end
        endcase
      end else if (conv_pending) begin
        // The request is used up even when the reply is dropped
        conv_pending = 1'b0;
        if (ready) begin
          add(siocp_pkg::KIND_REPLY, siocp_pkg::CH_STAR, 3'd0);
          add(siocp_pkg::KIND_REPLY, siocp_pkg::CH_C, 3'd0);
          add(siocp_pkg::KIND_REPLY, {siocp_pkg::ASCII_HI, 1'b0, pend_ch}, 3'd0);
          rest = adc;
          for (k = 0; k < 4; k++) begin
            add(siocp_pkg::KIND_REPLY, {siocp_pkg::ASCII_HI, 4'(rest % 10)}, 3'd0);
            rest = rest / 10;
          end
          add(siocp_pkg::KIND_REPLY, siocp_pkg::CH_CR, 3'd0);
        end
      end
      if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
      for (k = 0; k < batch.size(); k++) owed_words.push_back(batch[k]);
    endfunction

    function void check_word(logic [1:0] kind, logic [7:0] reply, logic last,
                             logic [7:0] led, logic [2:0] chan);
      out_word_t w;
      if (owed_words.size() == 0) begin
        $error("unexpected output word: kind %0d reply 0x%02h last %0d",
               kind, reply, last);
        errors++;
        return;
      end
      w = owed_words.pop_front();
      if (kind !== w.kind) begin
        $error("kind: expected %0d, actual %0d", w.kind, kind);
        errors++;
      end
      if (reply !== w.reply) begin
        $error("reply_byte: expected 0x%02h, actual 0x%02h", w.reply, reply);
        errors++;
      end
      if (last !== w.last) begin
        $error("last: expected %0d, actual %0d", w.last, last);
        errors++;
      end
      if (led !== w.led) begin
        $error("led_outputs: expected 0x%02h, actual 0x%02h", w.led, led);
        errors++;
      end
      if (chan !== w.chan) begin
        $error("conv_channel: expected %0d, actual %0d", w.chan, chan);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block under test
  // --------------------------------------------------------------------------
  logic                              clk_i         = 1'b0;
  logic                              rst_ni        = 1'b0;
  logic                              s_axis_tvalid = 1'b0;
  logic                              s_axis_tready;
  logic [siocp_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                              s_axis_tuser  = 1'b0;
  logic                              m_axis_tvalid;
  logic                              m_axis_tready = 1'b0;
  logic [siocp_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic [1:0]                        m_axis_tuser;
  logic                              m_axis_tlast;

  cmd_scoreboard sb;
  int            tx_idle_pct = 15;
  int            rx_idle_pct = 84;
  int            cycle_cnt   = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  serial_io_command_parser_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Hard stop in case the parser hangs or stops draining
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: stall at random on the falling edge, one decision per cycle
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Check every word taken on the output stream
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_word(m_axis_tuser, m_axis_tdata[7:0], m_axis_tlast,
                    m_axis_tdata[15:8], m_axis_tdata[18:16]);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus tasks
  // --------------------------------------------------------------------------

  // Present one input word after a random gap, hold it until accepted
  task automatic put_word(input logic op, input logic [7:0] rx,
                          input logic [7:0] pins, input logic [9:0] adc,
                          input logic ready);
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {5'b0, ready, adc, pins, rx};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_word(op, rx, pins, adc, ready);
  endtask

  // Command byte with random pins, converter value and mostly ready
  task automatic send_byte(input logic [7:0] rx);
    put_word(OP_BYTE, rx, 8'($urandom_range(255)), 10'($urandom_range(1023)),
             $urandom_range(99) < 85);
  endtask

  task automatic send_text(input string s, input logic [7:0] pins,
                           input logic ready);
    int i;
    for (i = 0; i < s.len(); i++)
      put_word(OP_BYTE, s[i], pins, 10'($urandom_range(1023)), ready);
  endtask

  // Well-formed command with random arguments; the final byte is mostly CR
  task automatic send_cmd(input logic [7:0] letter, input int nargs,
                          output int sent);
    int i;
    send_byte(siocp_pkg::CH_STAR);
    send_byte(letter);
    for (i = 0; i < nargs; i++) begin
      if ($urandom_range(1) == 0) send_byte(8'h30 + 8'($urandom_range(7)));
      else send_byte(8'($urandom_range(255)));
    end
    if ($urandom_range(9) != 0) send_byte(siocp_pkg::CH_CR);
    else send_byte(8'($urandom_range(255)));
    sent = nargs + 3;
  endtask

  task automatic run_directed();
    put_word(OP_BYTE, 8'h00, 8'h00, 10'h000, 1'b0);  // stray null byte
    send_text("*A\377\377\r", 8'hFF, 1'b1);  // channel and value bytes all ones
    // Set bit 2 to its current value and finish a status request on one CR
    send_text("*A*B\r", 8'hA5, 1'b1);
    send_text("*A01*", 8'h5A, 1'b1);         // final byte not CR: no update
    // Leading star in second place resets, then a status reply is dropped
    send_text("**B\r", 8'h00, 1'b0);
    send_text("*C\377\r", 8'h3C, 1'b1);      // request channel 7
    send_text("*C\370\r", 8'hC3, 1'b1);      // replace it with channel 0
    put_word(OP_DONE, 8'hFF, 8'hFF, 10'h000, 1'b0);  // consumed, nothing sent
    put_word(OP_DONE, 8'h00, 8'h00, 10'h3FF, 1'b1);  // nothing pending: ignored
  endtask

  // Mostly well-formed commands; completions follow pending requests
  task automatic run_random(input int n_items);
    int         done;
    int         pick;
    int         sent;
    logic [9:0] adc;
    done = 0;
    while (done < n_items) begin
      pick = $urandom_range(99);
      if (sb.conv_pending && pick < 30) begin
        case ($urandom_range(7))
          0:       adc = 10'd0;
          1:       adc = 10'd1023;
          default: adc = 10'($urandom_range(1023));
        endcase
        put_word(OP_DONE, 8'($urandom_range(255)), 8'($urandom_range(255)), adc,
                 $urandom_range(99) < 85);
        done++;
      end else if (pick < 50) begin
        send_cmd(siocp_pkg::CH_A, 2, sent);
        done += sent;
      end else if (pick < 65) begin
        send_cmd(siocp_pkg::CH_B, 0, sent);
        done += sent;
      end else if (pick < 80) begin
        send_cmd(siocp_pkg::CH_C, 1, sent);
        done += sent;
      end else if (pick < 92) begin
        send_byte(8'($urandom_range(255)));
        done++;
      end else if (pick < 97) begin
        // Broken start: star then a letter, another star or noise
        send_byte(siocp_pkg::CH_STAR);
        case ($urandom_range(4))
          0:       send_byte(siocp_pkg::CH_STAR);
          1:       send_byte(siocp_pkg::CH_A);
          2:       send_byte(siocp_pkg::CH_B);
          3:       send_byte(siocp_pkg::CH_C);
          default: send_byte(8'($urandom_range(255)));
        endcase
        done += 2;
      end else if (!sb.conv_pending) begin
        // Completion with no request behind it: ignored, not counted
        put_word(OP_DONE, 8'($urandom_range(255)), 8'($urandom_range(255)),
                 10'($urandom_range(1023)), 1'b1);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    sb = new();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Slow receiver: words back up and the queue fills
    tx_idle_pct = 15;
    rx_idle_pct = 84;
    run_directed();
    run_random(104);

    // Slow sender: output mostly idle between items
    tx_idle_pct = 84;
    rx_idle_pct = 15;
    run_random(103);

    // Full rate on both sides
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random(103);

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    // Drain, then give stray words a chance to show up
    rx_idle_pct = 0;
    while (sb.owed_words.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (sb.errors == 0 && sb.owed_words.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
